[design/assert_macros.svh]
// Assertion helpers used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define CHK_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// Next-cycle implication checked outside reset
`define CHK_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

[design/mgb_pkg.sv]
package mgb_pkg;

   localparam int unsigned CoordW  = 32;
   localparam int unsigned SumW    = 42;
   localparam int unsigned FirstW  = 26;
   localparam int unsigned CountW  = 10;
   localparam int unsigned LimitW  = 9;
   localparam int unsigned CsrIdxW = 1;

   // Hard cap on triangles per meshlet; the 10-bit index count is sized for it
   localparam int unsigned MaxGroupTris = 256;

   localparam logic [CsrIdxW-1:0] CSR_MAX_TRIS = 1'd0;
   localparam logic [CsrIdxW-1:0] CSR_CENTRE   = 1'd1;

   typedef logic signed [CoordW-1:0] coord_type;
   typedef logic signed [SumW-1:0]   sum_type;

   // Closed meshlet handed from the front to the back
   typedef struct packed {
      logic [FirstW-1:0] first_index;
      logic [CountW-1:0] index_count;
      coord_type [2:0]   box_low;
      coord_type [2:0]   box_high;
      sum_type [2:0]     vsum;
      logic              centre_mode;
      logic              run_end;
   } meshlet_type;

   typedef struct packed {
      logic [FirstW-1:0] first_index;
      logic [CountW-1:0] index_count;
      coord_type [2:0]   box_low;
      coord_type [2:0]   box_high;
      coord_type [2:0]   centre;
      logic              run_end;
   } result_type;

endpackage

[design/mgb_req_if.sv]
interface mgb_req_if;
   import mgb_pkg::*;
   logic      valid;
   logic      ready;
   coord_type ax, ay, az, bx, by, bz, cx, cy, cz;
   logic [31:0] line_id;
   logic      last_triangle;
   modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, line_id,
                   last_triangle, input ready);
   modport sink (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, line_id,
                 last_triangle, output ready);
endinterface

[design/mgb_rsp_if.sv]
interface mgb_rsp_if;
   import mgb_pkg::*;
   logic              valid;
   logic              ready;
   logic [FirstW-1:0] first_index;
   logic [CountW-1:0] index_count;
   coord_type min_x, min_y, min_z, max_x, max_y, max_z;
   coord_type centre_x, centre_y, centre_z;
   logic              run_end;
   modport source (output valid, first_index, index_count, min_x, min_y, min_z,
                   max_x, max_y, max_z, centre_x, centre_y, centre_z, run_end,
                   input ready);
   modport sink (input valid, first_index, index_count, min_x, min_y, min_z,
                 max_x, max_y, max_z, centre_x, centre_y, centre_z, run_end,
                 output ready);
endinterface

[design/mgb_front.sv]
// Accumulates triangles into the open meshlet and pushes closed meshlets
module mgb_front import mgb_pkg::*; #(
   parameter int unsigned TRI_COUNT_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   mgb_req_if.sink     req,
   input  logic [LimitW-1:0] max_tris,
   input  logic        centre_mode,
   output logic        push,
   output meshlet_type push_data,
   input  logic        q_free2
);
   localparam logic [LimitW:0] MaxLim = (LimitW+1)'(MaxGroupTris);

   logic [FirstW-1:0]         first_ff, first_in;
   logic [CountW-1:0]         count_ff, count_in;
   logic [31:0]               line_ff, line_in;
   coord_type [2:0]           lo_ff, lo_in, hi_ff, hi_in;
   sum_type [2:0]             sum_ff, sum_in;
   logic [TRI_COUNT_BITS-1:0] tri_ff, tri_in;
   // 2nd result of an item waits in pend_data_ff and is pushed in the next cycle
   logic        pend_ff, pend_in;
   meshlet_type pend_data_ff, pend_data_in;

   logic [LimitW:0]   limit;
   logic [CountW+1:0] limit3;
   logic              close_early, acc;
   logic [FirstW-1:0] pos;
   coord_type [2:0]   vx, vy, vz;
   coord_type [2:0]   lo_a, hi_a;
   sum_type [2:0]     sum_a;
   logic [CountW-1:0] count_a;
   meshlet_type       early_m, final_m;

   assign req.ready = q_free2 && !pend_ff;
   assign acc = req.valid && req.ready;

   always_comb begin
      limit = {1'b0, max_tris};
      if (limit == '0) limit = (LimitW+1)'(1);
      if (limit > MaxLim) limit = MaxLim;
      limit3 = (CountW+2)'(limit) * (CountW+2)'(3);
   end

   assign pos = FirstW'({{(FirstW+2){1'b0}}, tri_ff} * (FirstW+2+TRI_COUNT_BITS)'(3));
   assign close_early = ((CountW+2)'(count_ff) >= limit3)
                        || (req.line_id != line_ff && count_ff != '0);

   assign vx = '{req.cx, req.bx, req.ax};
   assign vy = '{req.cy, req.by, req.ay};
   assign vz = '{req.cz, req.bz, req.az};

   // Fold the triangle into the (possibly freshly cleared) meshlet
   always_comb begin
      coord_type [2:0] l0, h0;
      sum_type [2:0]   s0;
      coord_type       p;
      for (int a = 0; a < 3; a++) begin
         l0[a] = close_early ? coord_type'(32'sh7FFFFFFF) : lo_ff[a];
         h0[a] = close_early ? coord_type'(32'sh80000000) : hi_ff[a];
         s0[a] = close_early ? '0 : sum_ff[a];
      end
      for (int a = 0; a < 3; a++) begin
         lo_a[a] = l0[a]; hi_a[a] = h0[a]; sum_a[a] = s0[a];
         for (int v = 0; v < 3; v++) begin
            p = (a == 0) ? vx[v] : (a == 1) ? vy[v] : vz[v];
            if (p < lo_a[a]) lo_a[a] = p;
            if (p > hi_a[a]) hi_a[a] = p;
            sum_a[a] = sum_a[a] + SumW'(p);
         end
      end
      count_a = (close_early ? '0 : count_ff) + CountW'(3);
   end

   always_comb begin
      early_m.first_index = first_ff;
      early_m.index_count = count_ff;
      early_m.box_low     = lo_ff;
      early_m.box_high    = hi_ff;
      early_m.vsum        = sum_ff;
      early_m.centre_mode = centre_mode;
      early_m.run_end     = !req.last_triangle;
      final_m.first_index = close_early ? pos : first_ff;
      final_m.index_count = count_a;
      final_m.box_low     = lo_a;
      final_m.box_high    = hi_a;
      final_m.vsum        = sum_a;
      final_m.centre_mode = centre_mode;
      final_m.run_end     = 1'b1;
   end

   // Push selection: pending second result, else early close, else flush
   always_comb begin
      push = 1'b0;
      push_data = final_m;
      pend_in = pend_ff;
      pend_data_in = pend_data_ff;
      if (pend_ff) begin
         push = 1'b1;
         push_data = pend_data_ff;
         pend_in = 1'b0;
      end else if (acc) begin
         if (close_early) begin
            push = 1'b1;
            push_data = early_m;
            if (req.last_triangle) begin
               pend_in = 1'b1;
               pend_data_in = final_m;
            end
         end else if (req.last_triangle) begin
            push = 1'b1;
            push_data = final_m;
         end
      end
   end

   always_comb begin
      first_in = first_ff; count_in = count_ff; line_in = line_ff;
      lo_in = lo_ff; hi_in = hi_ff; sum_in = sum_ff; tri_in = tri_ff;
      if (acc) begin
         if (req.last_triangle) begin
            first_in = '0; count_in = '0; line_in = '0; tri_in = '0;
            for (int a = 0; a < 3; a++) begin
               lo_in[a] = coord_type'(32'sh7FFFFFFF);
               hi_in[a] = coord_type'(32'sh80000000);
               sum_in[a] = '0;
            end
         end else begin
            first_in = close_early ? pos : first_ff;
            count_in = count_a; line_in = req.line_id;
            lo_in = lo_a; hi_in = hi_a; sum_in = sum_a;
            tri_in = tri_ff + TRI_COUNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= '0; count_ff <= '0; line_ff <= '0; tri_ff <= '0;
         pend_ff <= 1'b0;
         for (int a = 0; a < 3; a++) begin
            lo_ff[a] <= coord_type'(32'sh7FFFFFFF);
            hi_ff[a] <= coord_type'(32'sh80000000);
            sum_ff[a] <= '0;
         end
      end else begin
         first_ff <= first_in; count_ff <= count_in; line_ff <= line_in;
         lo_ff <= lo_in; hi_ff <= hi_in; sum_ff <= sum_in; tri_ff <= tri_in;
         pend_ff <= pend_in;
      end
      pend_data_ff <= pend_data_in;
   end
endmodule

[design/mgb_queue.sv]
// Small FIFO of closed meshlets between front and back
module mgb_queue import mgb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  meshlet_type push_data,
   output logic        free2,
   output logic        not_empty,
   input  logic        pop,
   output meshlet_type head
);
   localparam int unsigned Depth = 4;
   meshlet_type mem_ff [Depth];
   logic [1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0] cnt_ff, cnt_in;

   assign not_empty = cnt_ff != '0;
   assign free2 = cnt_ff <= 3'(Depth - 2);
   assign head = mem_ff[rp_ff];

   always_comb begin
      wp_in = wp_ff + 2'(push);
      rp_in = rp_ff + 2'(pop);
      cnt_in = cnt_ff + 3'(push) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= push_data;
   end
endmodule

[design/mgb_back.sv]
// Computes the centre of one meshlet at a time: box midpoint, or restoring divider for averages
module mgb_back import mgb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  meshlet_type q_head,
   output logic        q_pop,
   mgb_rsp_if.source   rsp
);
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_OUT  = 3'b100
   } state_type;

   state_type         st_ff, st_in;
   meshlet_type       m_ff, m_in;
   logic [1:0]        axis_ff, axis_in;
   logic [5:0]        bit_ff, bit_in;
   logic [SumW-1:0]   quo_ff, quo_in, num_ff, num_in;
   logic [CountW:0]   rem_ff, rem_in;
   coord_type [2:0]   cen_ff, cen_in;
   logic              ovalid_ff, ovalid_in;
   result_type        out_ff, out_in;

   logic [CountW:0]   trial;
   logic              neg;
   logic [SumW-1:0]   q_signed;
   logic signed [CoordW:0] mid;

   assign neg = m_ff.vsum[axis_ff][SumW-1];
   assign trial = {rem_ff[CountW-1:0], num_ff[SumW-1]};
   assign q_pop = (st_ff == ST_IDLE) && q_valid;

   always_comb begin
      st_in = st_ff; m_in = m_ff; axis_in = axis_ff; bit_in = bit_ff;
      quo_in = quo_ff; num_in = num_ff; rem_in = rem_ff; cen_in = cen_ff;
      ovalid_in = ovalid_ff; out_in = out_ff;
      q_signed = '0; mid = '0;
      if (ovalid_ff && rsp.ready) ovalid_in = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (q_valid) begin
               m_in = q_head;
               if (q_head.centre_mode) begin
                  for (int a = 0; a < 3; a++) begin
                     mid = (CoordW+1)'(q_head.box_low[a]) + (CoordW+1)'(q_head.box_high[a]);
                     cen_in[a] = coord_type'(mid >>> 1);
                  end
                  st_in = ST_OUT;
               end else begin
                  axis_in = '0;
                  bit_in = 6'(SumW - 1);
                  rem_in = '0;
                  quo_in = '0;
                  num_in = q_head.vsum[0][SumW-1] ? -q_head.vsum[0] : q_head.vsum[0];
                  st_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            // One quotient bit per cycle on |sum| / count
            if (trial >= {1'b0, m_ff.index_count}) begin
               rem_in = trial - {1'b0, m_ff.index_count};
               quo_in = {quo_ff[SumW-2:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[SumW-2:0], 1'b0};
            end
            num_in = {num_ff[SumW-2:0], 1'b0};
            bit_in = bit_ff - 6'd1;
            if (bit_ff == '0) begin
               q_signed = neg ? -quo_in : quo_in;
               cen_in[axis_ff] = coord_type'(q_signed[CoordW-1:0]);
               if (axis_ff == 2'd2) begin
                  st_in = ST_OUT;
               end else begin
                  axis_in = axis_ff + 2'd1;
                  bit_in = 6'(SumW - 1);
                  rem_in = '0;
                  quo_in = '0;
                  num_in = m_ff.vsum[axis_in][SumW-1] ? -m_ff.vsum[axis_in]
                                                      : m_ff.vsum[axis_in];
               end
            end
         end
         ST_OUT: begin
            if (!ovalid_ff || rsp.ready) begin
               ovalid_in = 1'b1;
               out_in.first_index = m_ff.first_index;
               out_in.index_count = m_ff.index_count;
               out_in.box_low = m_ff.box_low;
               out_in.box_high = m_ff.box_high;
               out_in.centre = cen_ff;
               out_in.run_end = m_ff.run_end;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         ovalid_ff <= ovalid_in;
      end
      m_ff <= m_in; axis_ff <= axis_in; bit_ff <= bit_in; quo_ff <= quo_in;
      num_ff <= num_in; rem_ff <= rem_in; cen_ff <= cen_in; out_ff <= out_in;
   end

   assign rsp.valid = ovalid_ff;
   assign rsp.first_index = out_ff.first_index;
   assign rsp.index_count = out_ff.index_count;
   assign rsp.min_x = out_ff.box_low[0];
   assign rsp.min_y = out_ff.box_low[1];
   assign rsp.min_z = out_ff.box_low[2];
   assign rsp.max_x = out_ff.box_high[0];
   assign rsp.max_y = out_ff.box_high[1];
   assign rsp.max_z = out_ff.box_high[2];
   assign rsp.centre_x = out_ff.centre[0];
   assign rsp.centre_y = out_ff.centre[1];
   assign rsp.centre_z = out_ff.centre[2];
   assign rsp.run_end = out_ff.run_end;
endmodule

[design/meshlet_grouper_with_bounds_unit.sv]
// Meshlet grouper: one triangle per cycle is taken while the queue has room and no
// second result is pending. A meshlet closes in the accept cycle; its result passes
// through the queue and the back end's registers, in average mode through the serial
// divider first (one quotient bit per cycle). There the divider sets the sustained meshlet rate.
// Reset (synchronous, active high) empties the meshlet, queue and counter and restores the configuration defaults.
module meshlet_grouper_with_bounds_unit import mgb_pkg::*; #(
   parameter int unsigned TRI_COUNT_BITS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   mgb_req_if.sink              req,
   mgb_rsp_if.source            rsp,
   input  logic                 csr_we,
   input  logic [CsrIdxW-1:0]   csr_index,
   input  logic [LimitW-1:0]    csr_data
);
   logic [LimitW-1:0] max_tris_ff;
   logic              centre_ff;
   logic              push, free2, q_valid, q_pop;
   meshlet_type       push_data, head;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_tris_ff <= LimitW'(64);
         centre_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_TRIS: max_tris_ff <= csr_data;
            CSR_CENTRE:   centre_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   mgb_front #(.TRI_COUNT_BITS(TRI_COUNT_BITS)) u_front (
      .clock, .reset, .req, .max_tris(max_tris_ff), .centre_mode(centre_ff),
      .push, .push_data, .q_free2(free2)
   );

   mgb_queue u_queue (
      .clock, .reset, .push, .push_data, .free2, .not_empty(q_valid),
      .pop(q_pop), .head
   );

   mgb_back u_back (
      .clock, .reset, .q_valid, .q_head(head), .q_pop, .rsp
   );
endmodule

[design/mgb_checker.sv]
`include "assert_macros.svh"
// Port-level checks on the grouper
module mgb_checker import mgb_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [CountW-1:0] rsp_index_count,
   input coord_type         rsp_min_x,
   input coord_type         rsp_max_x
);
   `CHK_IMPLY(a_count_min, clock, reset, rsp_valid, rsp_index_count >= CountW'(3), "empty meshlet")
   `CHK_IMPLY(a_box_order, clock, reset, rsp_valid, rsp_min_x <= rsp_max_x, "box min above max")
   `CHK_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_index_count), "stalled response changed")
endmodule

bind meshlet_grouper_with_bounds_unit mgb_checker u_chk (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_index_count(rsp.index_count), .rsp_min_x(rsp.min_x), .rsp_max_x(rsp.max_x)
);

[sim/tb_top.sv]
module tb_top import mgb_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned GroupCap    = 256;
   localparam int unsigned CountBits   = 24;
   localparam int unsigned SettleDelay = 200;

   typedef struct packed {
      coord_type [8:0] p;   // ax ay az bx by bz cx cy cz, index 0 = ax
      logic [31:0]     line_id;
      logic            last_triangle;
   } triangle_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                csr_we    = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = CSR_MAX_TRIS;
   logic [LimitW-1:0]   csr_data  = '0;

   mgb_req_if req ();
   mgb_rsp_if rsp ();

   meshlet_grouper_with_bounds_unit #(
      .TRI_COUNT_BITS(CountBits)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shared testbench state
   triangle_type tri_queue[$];
   result_type   meshlet_expect_q[$];
   int unsigned  tri_accepted = 0;
   int unsigned  fail_count   = 0;
   bit           calm_phase   = 1'b0;   // no idling on either side
   bit           hold_done    = 1'b0;
   int unsigned  hold_left    = 0;

   // predictor state
   int unsigned     cfg_max_tris  = 64;
   bit              cfg_centre    = 1'b0;
   int unsigned     m_first       = 0;
   int unsigned     m_count       = 0;
   logic [31:0]     m_line        = '0;
   longint signed   m_low[3];
   longint signed   m_high[3];
   longint signed   m_sum[3];
   int unsigned     m_tri_count   = 0;

   // append one triangle to the pending stimulus
   function automatic void add_tri(triangle_type t);
      tri_queue = {tri_queue, t};
   endfunction

   function automatic void clear_meshlet();
      m_first = 0;
      m_count = 0;
      for (int a = 0; a < 3; a++) begin
         m_low[a]  = 64'sd2147483647;
         m_high[a] = -64'sd2147483648;
         m_sum[a]  = 0;
      end
   endfunction

   function automatic void close_meshlet(bit run_end);
      result_type r;
      longint signed c;
      r.first_index = m_first[FirstW-1:0];
      r.index_count = m_count[CountW-1:0];
      r.run_end     = run_end;
      for (int a = 0; a < 3; a++) begin
         r.box_low[a]  = m_low[a][31:0];
         r.box_high[a] = m_high[a][31:0];
         if (!cfg_centre) begin
            c = (m_count != 0) ? m_sum[a] / longint'(m_count) : 0;
         end else begin
            c = m_low[a] + m_high[a];
            c = (c < 0) ? (c - 1) / 2 : c / 2;
         end
         r.centre[a] = c[31:0];
      end
      meshlet_expect_q = {meshlet_expect_q, r};
   endfunction

   // fold one accepted triangle into the open meshlet
   function automatic void fold_triangle(triangle_type t);
      int unsigned limit;
      int unsigned pos;
      longint signed v;
      limit = cfg_max_tris;
      if (limit == 0) limit = 1;
      if (limit > GroupCap) limit = GroupCap;
      pos = (m_tri_count * 3) & 32'h3FF_FFFF;
      if (m_count >= limit * 3 || (t.line_id != m_line && m_count > 0)) begin
         close_meshlet(!t.last_triangle);
         clear_meshlet();
         m_first = pos;
      end
      m_line = t.line_id;
      for (int k = 0; k < 9; k++) begin
         v = longint'(t.p[k]);
         if (v < m_low[k % 3])  m_low[k % 3]  = v;
         if (v > m_high[k % 3]) m_high[k % 3] = v;
         m_sum[k % 3] += v;
      end
      m_count += 3;
      m_tri_count = (m_tri_count + 1) & ((1 << CountBits) - 1);
      if (t.last_triangle) begin
         close_meshlet(1'b1);
         clear_meshlet();
         m_line = '0;
         m_tri_count = 0;
      end
   endfunction

   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm_phase || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // request driver
   triangle_type cur_tri;
   int unsigned  send_gap = 0;
   always @(posedge clock) begin
      bit fired;
      fired = 1'b0;
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            fold_triangle(cur_tri);
            tri_accepted <= tri_accepted + 1;
            fired = 1'b1;
         end
         if (req.valid && !fired) begin
            // hold the current request
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req.valid <= 1'b0;
         end else if (tri_queue.size() > 0) begin
            cur_tri = tri_queue.pop_front();
            req.valid <= 1'b1;
            req.ax <= cur_tri.p[0]; req.ay <= cur_tri.p[1]; req.az <= cur_tri.p[2];
            req.bx <= cur_tri.p[3]; req.by <= cur_tri.p[4]; req.bz <= cur_tri.p[5];
            req.cx <= cur_tri.p[6]; req.cy <= cur_tri.p[7]; req.cz <= cur_tri.p[8];
            req.line_id <= cur_tri.line_id;
            req.last_triangle <= cur_tri.last_triangle;
            send_gap <= idle_len();
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   initial begin
      req.valid = 1'b0;
      req.ax = '0; req.ay = '0; req.az = '0; req.bx = '0; req.by = '0;
      req.bz = '0; req.cx = '0; req.cy = '0; req.cz = '0;
      req.line_id = '0;
      req.last_triangle = 1'b0;
      rsp.ready = 1'b0;
   end

   // long receiver hold-off once the stream is under way
   always @(posedge clock) begin
      if (!reset) begin
         if (!hold_done && tri_accepted >= 300) begin
            hold_done <= 1'b1;
            hold_left <= 600;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
         end
      end
   end

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %h actual %h", $realtime, name, want, got);
         fail_count++;
      end
   endtask

   // response monitor and ready pacing
   int unsigned recv_gap = 0;
   always @(posedge clock) begin
      result_type e;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (meshlet_expect_q.size() == 0) begin
               $display("%0t: unexpected meshlet first_index %h count %0d", $realtime,
                        rsp.first_index, rsp.index_count);
               fail_count++;
            end else begin
               e = meshlet_expect_q.pop_front();
               check_field("first_index", 32'(e.first_index), 32'(rsp.first_index));
               check_field("index_count", 32'(e.index_count), 32'(rsp.index_count));
               check_field("min_x", e.box_low[0], rsp.min_x);
               check_field("min_y", e.box_low[1], rsp.min_y);
               check_field("min_z", e.box_low[2], rsp.min_z);
               check_field("max_x", e.box_high[0], rsp.max_x);
               check_field("max_y", e.box_high[1], rsp.max_y);
               check_field("max_z", e.box_high[2], rsp.max_z);
               check_field("centre_x", e.centre[0], rsp.centre_x);
               check_field("centre_y", e.centre[1], rsp.centre_y);
               check_field("centre_z", e.centre[2], rsp.centre_z);
               check_field("run_end", 32'(e.run_end), 32'(rsp.run_end));
            end
         end
         if (hold_left > 0) begin
            rsp.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
            if (rsp.valid && rsp.ready) recv_gap <= idle_len();
         end
      end
   end

   function automatic coord_type pick_coord(int unsigned style, coord_type centre_c);
      case (style)
         0: return centre_c + coord_type'($urandom_range(0, 4095)) - 2048;
         1: return coord_type'($urandom);
         default: begin
            case ($urandom_range(0, 3))
               0: return 32'sh7FFF_FFFF;
               1: return 32'sh8000_0000;
               2: return '0;
               default: return -1;
            endcase
         end
      endcase
   endfunction

   function automatic triangle_type make_tri(int unsigned style, coord_type base[3],
                                             logic [31:0] line, bit last);
      triangle_type t;
      for (int k = 0; k < 9; k++) t.p[k] = pick_coord(style, base[k % 3]);
      t.line_id = line;
      t.last_triangle = last;
      return t;
   endfunction

   // well-formed polyline runs, with an occasional early flush
   task automatic queue_runs(int unsigned count);
      int unsigned made;
      int unsigned len;
      int unsigned style;
      int unsigned r;
      logic [31:0] line;
      coord_type base[3];
      bit last;
      made = 0;
      line = '0;
      while (made < count) begin
         r = $urandom_range(0, 99);
         if (r < 10) line = '0;
         else if (r < 20) line = line;
         else if (r < 60) line = line + $urandom_range(1, 64);
         else line = $urandom;
         r = $urandom_range(0, 99);
         len = (r < 85) ? $urandom_range(1, 12) : $urandom_range(20, 280);
         r = $urandom_range(0, 99);
         style = (r < 70) ? 0 : (r < 85) ? 1 : 2;
         for (int a = 0; a < 3; a++) base[a] = coord_type'($urandom);
         for (int i = 0; i < len && made < count; i++) begin
            last = ($urandom_range(0, 59) == 0) ||
                   (i == len - 1 && $urandom_range(0, 5) == 0);
            add_tri(make_tri(style, base, line, last));
            made++;
         end
      end
   endtask

   task automatic write_csr(logic [CsrIdxW-1:0] idx, int unsigned value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[LimitW-1:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_MAX_TRIS) cfg_max_tris = value & 32'h1FF;
      else cfg_centre = value[0];
   endtask

   task automatic wait_idle();
      while (tri_queue.size() > 0 || req.valid || meshlet_expect_q.size() > 0)
         @(posedge clock);
      repeat (SettleDelay) @(posedge clock);
   endtask

   initial begin
      coord_type base[3];
      int unsigned limits[8];
      bit          modes[8];
      clear_meshlet();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, line changes, flushes, at reset settings and then in midpoint mode
      base[0] = '0; base[1] = '0; base[2] = '0;
      calm_phase = 1'b1;
      add_tri(make_tri(2, base, 32'd5, 1'b1));
      add_tri('{p: {9{32'sh7FFF_FFFF}}, line_id: 32'hFFFF_FFFF, last_triangle: 1'b0});
      add_tri('{p: {9{32'sh8000_0000}}, line_id: 32'hFFFF_FFFF, last_triangle: 1'b0});
      add_tri('{p: {9{32'sh8000_0000}}, line_id: 32'hFFFF_FFFF, last_triangle: 1'b1});
      // line change right after a flush: nothing closes
      add_tri(make_tri(0, base, 32'd7, 1'b0));
      add_tri(make_tri(0, base, 32'd7, 1'b0));
      add_tri(make_tri(0, base, 32'd8, 1'b0));
      add_tri('{p: {{3{32'sh0000_0003}}, {3{-32'sd7}}, {3{32'sd1}}},
                line_id: 32'd9, last_triangle: 1'b1});
      for (int i = 0; i < 6; i++) add_tri(make_tri(1, base, 32'd0, i == 5));
      wait_idle();
      write_csr(CSR_CENTRE, 1);
      add_tri('{p: {{3{32'sh7FFF_FFFF}}, {3{32'sh8000_0000}}, {3{-32'sd1}}},
                line_id: 32'd1, last_triangle: 1'b1});
      add_tri('{p: {9{-32'sd3}}, line_id: 32'd2, last_triangle: 1'b0});
      add_tri('{p: {9{32'sd4}}, line_id: 32'd2, last_triangle: 1'b0});
      add_tri(make_tri(2, base, 32'd3, 1'b1));
      wait_idle();
      calm_phase = 1'b0;

      // random phases across settings, extremes included
      limits = '{1, 0, 256, 511, 3, 64, 257, 17};
      modes  = '{0, 1, 0, 1, 1, 0, 1, 0};
      for (int ph = 0; ph < 8; ph++) begin
         write_csr(CSR_MAX_TRIS, limits[ph]);
         write_csr(CSR_CENTRE, modes[ph]);
         calm_phase = (ph == 5);
         queue_runs(ph == 2 ? 320 : 180);
         wait_idle();
      end

      if (meshlet_expect_q.size() != 0) fail_count++;
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #12000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
